FILE: rtl/cdd_pkg.sv
// Shared widths, calendar constants and leap/month-length functions for the date difference block.
`timescale 1ns / 1ps

package cdd_pkg;

    localparam int unsigned YearW  = 14;
    localparam int unsigned MonthW = 4;
    localparam int unsigned DayW   = 5;
    localparam int unsigned DiffYW = 15;
    localparam int unsigned DiffDW = 6;

    typedef logic [YearW-1:0]         t_year;
    typedef logic [MonthW-1:0]        t_month;
    typedef logic [DayW-1:0]          t_day;
    typedef logic signed [DiffYW-1:0] t_diff_year;
    typedef logic signed [DiffDW-1:0] t_diff_day;

    localparam t_year  YearMin     = 14'd1800;
    localparam t_year  YearMax     = 14'd9999;
    localparam t_month MonthJan    = 4'd1;
    localparam t_month MonthFeb    = 4'd2;
    localparam t_month MonthMar    = 4'd3;
    localparam t_month MonthApr    = 4'd4;
    localparam t_month MonthMay    = 4'd5;
    localparam t_month MonthJun    = 4'd6;
    localparam t_month MonthJul    = 4'd7;
    localparam t_month MonthSep    = 4'd9;
    localparam t_month MonthOct    = 4'd10;
    localparam t_month MonthNov    = 4'd11;
    localparam t_month MonthDec    = 4'd12;
    localparam t_month MonthsPerYr = 4'd12;
    localparam t_day   DaysFebLeap = 5'd29;
    localparam t_day   DaysFeb     = 5'd28;
    localparam t_day   DaysShort   = 5'd30;
    localparam t_day   DaysLong    = 5'd31;

    // floor(y / 100) equals (y * 5243) >> 19 for every 14-bit y.
    localparam logic [12:0] Recip100 = 13'd5243;
    localparam int unsigned RecipShift = 19;
    localparam logic [13:0] Hundred = 14'd100;

    // Gregorian leap test: divisible by 4 and not by 100, or divisible by 400.
    function automatic logic is_leap(input t_year y);
        logic [26:0] prod;
        logic [7:0]  q;
        logic [13:0] back;
        logic        div100;
        prod   = 27'(y) * 27'(Recip100);
        q      = prod[RecipShift +: 8];
        back   = 14'(q) * Hundred;
        div100 = (back == y);
        return ((y[1:0] == 2'b00) && !div100) || (div100 && (q[1:0] == 2'b00));
    endfunction

    // Length of month m; months outside 1..12 are rejected separately.
    function automatic t_day month_len(input t_month m, input logic leap);
        t_day len;
        unique case (m)
            MonthApr, MonthJun, MonthSep, MonthNov: len = DaysShort;
            MonthFeb: len = leap ? DaysFebLeap : DaysFeb;
            default:  len = DaysLong;
        endcase
        return len;
    endfunction

    // Days borrowed when the later date's day is short, keyed on its month.
    function automatic t_day borrow_len(input t_month m, input logic leap);
        t_day len;
        unique case (m)
            MonthMar: len = leap ? DaysFebLeap : DaysFeb;
            MonthMay, MonthJul, MonthOct, MonthDec: len = DaysShort;
            default:  len = DaysLong;
        endcase
        return len;
    endfunction

endpackage

FILE: rtl/calendar_date_difference.sv
// Top level: validates two Gregorian dates and subtracts them into years, months and days.
`timescale 1ns / 1ps

// Channel   Handshake            Payload                                       Direction
// -------   ------------------   -------------------------------------------   ---------
// command   start, busy          i_first_{year,month,day},                     in
//                                i_second_{year,month,day}
// result    o_done (1 cycle)     o_date_invalid, o_diff_years,                 out
//                                o_diff_months, o_diff_days
//
// A command transfer happens on every rising edge with start high and busy low. busy is
// never raised, so one date pair can be taken in every cycle. Each transfer produces exactly
// one result, which passes through the input register and then the result register before
// o_done rises with it. The receiver cannot stall the result port; each result is present
// for exactly one cycle. A synchronous low on i_rst_n drops any command in flight and
// clears o_done.

module calendar_date_difference (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  cdd_pkg::t_year           i_first_year,
    input  cdd_pkg::t_month          i_first_month,
    input  cdd_pkg::t_day            i_first_day,
    input  cdd_pkg::t_year           i_second_year,
    input  cdd_pkg::t_month          i_second_month,
    input  cdd_pkg::t_day            i_second_day,
    output logic                     o_done,
    output logic                     o_date_invalid,
    output cdd_pkg::t_diff_year      o_diff_years,
    output cdd_pkg::t_month          o_diff_months,
    output cdd_pkg::t_diff_day       o_diff_days
);
    import cdd_pkg::*;

    // Input register stage.
    logic   r_in_valid;
    t_year  r_y1, r_y2;
    t_month r_m1, r_m2;
    t_day   r_d1, r_d2;

    // Result register stage.
    logic       r_done;
    logic       r_invalid;
    t_diff_year r_diff_y;
    t_month     r_diff_m;
    t_diff_day  r_diff_d;

    logic       n_invalid;
    t_diff_year n_diff_y;
    t_month     n_diff_m;
    t_diff_day  n_diff_d;

    logic       leap1, leap2;
    logic       ok1, ok2;
    logic       day_borrow, month_borrow;
    t_day       borrow_days;
    logic signed [5:0] mm;         // later month after a day borrow, may reach zero
    logic signed [6:0] dd;         // later day plus borrow, minus earlier day

    // The block has no multi-cycle work, so it is always ready for a new command.
    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
            r_done     <= r_in_valid;
        end
        if (start && !busy) begin
            r_y1 <= i_first_year;
            r_m1 <= i_first_month;
            r_d1 <= i_first_day;
            r_y2 <= i_second_year;
            r_m2 <= i_second_month;
            r_d2 <= i_second_day;
        end
        if (r_in_valid) begin
            r_invalid <= n_invalid;
            r_diff_y  <= n_diff_y;
            r_diff_m  <= n_diff_m;
            r_diff_d  <= n_diff_d;
        end
    end

    always_comb begin
        leap1 = is_leap(r_y1);
        leap2 = is_leap(r_y2);

        // A date is valid when year, month and day all lie in range.
        ok1 = (r_y1 >= YearMin) && (r_y1 <= YearMax) &&
              (r_m1 >= MonthJan) && (r_m1 <= MonthDec) &&
              (r_d1 != '0) && (r_d1 <= month_len(r_m1, leap1));
        ok2 = (r_y2 >= YearMin) && (r_y2 <= YearMax) &&
              (r_m2 >= MonthJan) && (r_m2 <= MonthDec) &&
              (r_d2 != '0) && (r_d2 <= month_len(r_m2, leap2));
        n_invalid = !(ok1 && ok2);

        // Borrow days from the month before the later date's month, then borrow a year when the months fall short.
        day_borrow  = (r_d2 < r_d1);
        borrow_days = day_borrow ? borrow_len(r_m2, leap2) : '0;
        mm = $signed({2'b00, r_m2}) - $signed({5'd0, day_borrow});
        month_borrow = (mm < $signed({2'b00, r_m1}));
        dd = $signed({2'b00, r_d2}) + $signed({2'b00, borrow_days}) - $signed({2'b00, r_d1});

        if (n_invalid) begin
            n_diff_y = '0;
            n_diff_m = '0;
            n_diff_d = '0;
        end else begin
            n_diff_y = $signed({1'b0, r_y2}) - $signed({1'b0, r_y1})
                       - $signed({14'd0, month_borrow});
            n_diff_m = 4'(mm[3:0] + (month_borrow ? MonthsPerYr : 4'd0) - r_m1);
            n_diff_d = dd[5:0];
        end
    end

    assign o_done         = r_done;
    assign o_date_invalid = r_invalid;
    assign o_diff_years   = r_diff_y;
    assign o_diff_months  = r_diff_m;
    assign o_diff_days    = r_diff_d;

endmodule

FILE: rtl/cdd_checker.sv
// Port-level checker for the date difference block, bound to its top level.
`timescale 1ns / 1ps

module cdd_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic                o_done,
    input logic                o_date_invalid,
    input cdd_pkg::t_diff_year o_diff_years,
    input cdd_pkg::t_month     o_diff_months,
    input cdd_pkg::t_diff_day  o_diff_days
);
    import cdd_pkg::*;

    // Every command transfer yields a result on o_done, through the input and result registers.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_done)
        else $error("result missing two cycles after a command transfer");

    // No result appears without a matching earlier command transfer.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy && i_rst_n, 2))
        else $error("result without a matching command transfer");

    // A rejected date pair reports a zero difference.
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_date_invalid) |->
            (o_diff_years == '0 && o_diff_months == '0 && o_diff_days == '0))
        else $error("invalid result carries a nonzero difference");

    // After borrowing, months stay below a year and days no lower than minus three.
    a_valid_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_date_invalid) |->
            (o_diff_months <= MonthDec - 4'd1 && o_diff_days >= -6'sd3))
        else $error("months or days outside the borrowing range");

endmodule

bind calendar_date_difference cdd_checker u_cdd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_done         (o_done),
    .o_date_invalid (o_date_invalid),
    .o_diff_years   (o_diff_years),
    .o_diff_months  (o_diff_months),
    .o_diff_days    (o_diff_days)
);
